FILE: sv/acc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package acc_pkg;

    // Field widths
    localparam int LBA_W     = 48;
    localparam int CNT_W     = 16;
    localparam int BUF_W     = 32;
    localparam int ELEN_W    = 32;
    localparam int MODE_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    // Command opcodes
    localparam logic [7:0] OP_READ         = 8'hC8;
    localparam logic [7:0] OP_READ_EXT     = 8'h25;
    localparam logic [7:0] OP_WRITE        = 8'hCA;
    localparam logic [7:0] OP_WRITE_EXT    = 8'h35;
    localparam logic [7:0] OP_VERIFY       = 8'h40;
    localparam logic [7:0] OP_VERIFY_EXT   = 8'h42;
    localparam logic [7:0] OP_SET_FEATURES = 8'hEF;
    localparam logic [7:0] OP_SET_MULTIPLE = 8'hC6;
    localparam logic [7:0] OP_CHECK_POWER  = 8'hE5;
    localparam logic [7:0] OP_STANDBY      = 8'hE2;
    localparam logic [7:0] OP_IDENTIFY     = 8'hEC;
    localparam logic [7:0] OP_IDENTIFY_PKT = 8'hA1;
    localparam logic [7:0] OP_FLUSH        = 8'hE7;
    localparam logic [7:0] OP_FLUSH_EXT    = 8'hEA;

    // Set-features subcommand and transfer mode classes (upper nibble)
    localparam logic [7:0] FEAT_XFER_MODE = 8'h03;
    localparam logic [3:0] MODE_PIO       = 4'h0;
    localparam logic [3:0] MODE_MWDMA     = 4'h2;
    localparam logic [3:0] MODE_UDMA      = 4'h4;

    // Reset values
    localparam logic [MODE_W-1:0] PIO_RESET   = 16'h0000;
    localparam logic [MODE_W-1:0] MWDMA_RESET = 16'h0407;
    localparam logic [MODE_W-1:0] UDMA_RESET  = 16'h003f;
    localparam logic [LBA_W-1:0]  CAP_RESET   = 48'd1048576;
    localparam logic [3:0]        SHIFT_RESET = 4'd9;

    // Injection enable bits
    localparam int INJ_READ   = 0;
    localparam int INJ_WRITE  = 1;
    localparam int INJ_VERIFY = 2;

    localparam logic [LBA_W-1:0] LBA28_MASK = 48'h0000_0FFF_FFFF;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_ABORT = 2'd1,
        ERR_IDNF  = 2'd2,
        ERR_ECC   = 2'd3
    } err_code_t;

    typedef enum logic [1:0] {
        XFER_NONE  = 2'd0,
        XFER_READ  = 2'd1,
        XFER_WRITE = 2'd2
    } xfer_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAPACITY  = 3'd0,
        CFG_SHIFT     = 3'd1,
        CFG_LBA48     = 3'd2,
        CFG_INJECT    = 3'd3,
        CFG_ERR_START = 3'd4,
        CFG_ERR_LEN   = 3'd5
    } cfg_idx_t;

    // Register file contents plus the precomputed end of the error range
    typedef struct packed {
        logic [LBA_W-1:0]  capacity;
        logic [3:0]        block_shift;
        logic              lba48;
        logic [2:0]        inject_mask;
        logic [LBA_W-1:0]  error_start;
        logic [ELEN_W-1:0] error_length;
        logic [LBA_W:0]    error_end;
    } cfg_t;

    // Raw taskfile as captured at the input
    typedef struct packed {
        logic [7:0]       func;
        logic [7:0]       lba_low_cur;
        logic [7:0]       lba_mid_cur;
        logic [7:0]       lba_high_cur;
        logic [7:0]       lba_low_prv;
        logic [7:0]       lba_mid_prv;
        logic [7:0]       lba_high_prv;
        logic [7:0]       head_reg;
        logic [7:0]       count_cur;
        logic [7:0]       count_prv;
        logic [7:0]       feature_reg;
        logic [BUF_W-1:0] buffer_bytes;
    } cmd_t;

    // Assembled command with sums ready for the checks
    typedef struct packed {
        logic [7:0]       func;
        logic [7:0]       count_cur;
        logic [7:0]       feature_reg;
        logic [BUF_W-1:0] buffer_bytes;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] cnt;
        logic [LBA_W:0]   lba_end;
        logic [BUF_W-1:0] req_bytes;
    } asm_t;

    // Update one mode word: keep the supported byte, set the selected mode bit.
    // Mode numbers of 8 and above fall off the top of the word.
    function automatic logic [MODE_W-1:0] set_mode(input logic [MODE_W-1:0] w,
                                                   input logic [3:0] mode);
        logic [31:0] sel;
        sel = 32'd1 << (5'(mode) + 5'd8);
        return (w & 16'h00ff) | sel[MODE_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: sv/acc_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Command channel
interface acc_cmd_if;
    logic                     valid;
    logic                     ready;
    logic [7:0]               func;
    logic [7:0]               lba_low_cur;
    logic [7:0]               lba_mid_cur;
    logic [7:0]               lba_high_cur;
    logic [7:0]               lba_low_prv;
    logic [7:0]               lba_mid_prv;
    logic [7:0]               lba_high_prv;
    logic [7:0]               head_reg;
    logic [7:0]               count_cur;
    logic [7:0]               count_prv;
    logic [7:0]               feature_reg;
    logic [acc_pkg::BUF_W-1:0] buffer_bytes;

    modport source (
        output valid, func, lba_low_cur, lba_mid_cur, lba_high_cur,
               lba_low_prv, lba_mid_prv, lba_high_prv, head_reg,
               count_cur, count_prv, feature_reg, buffer_bytes,
        input  ready
    );
    modport sink (
        input  valid, func, lba_low_cur, lba_mid_cur, lba_high_cur,
               lba_low_prv, lba_mid_prv, lba_high_prv, head_reg,
               count_cur, count_prv, feature_reg, buffer_bytes,
        output ready
    );
endinterface

// Response channel
interface acc_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       status;
    logic [1:0]                 error_code;
    logic [1:0]                 transfer_kind;
    logic [acc_pkg::LBA_W-1:0]  start_lba;
    logic [acc_pkg::CNT_W-1:0]  sector_total;
    logic                       report_valid;
    logic [acc_pkg::LBA_W-1:0]  report_lba;
    logic [acc_pkg::MODE_W-1:0] pio_word;
    logic [acc_pkg::MODE_W-1:0] mwdma_word;
    logic [acc_pkg::MODE_W-1:0] udma_word;

    modport source (
        output valid, status, error_code, transfer_kind, start_lba, sector_total,
               report_valid, report_lba, pio_word, mwdma_word, udma_word,
        input  ready
    );
    modport sink (
        input  valid, status, error_code, transfer_kind, start_lba, sector_total,
               report_valid, report_lba, pio_word, mwdma_word, udma_word,
        output ready
    );
endinterface

// Configuration write channel
interface acc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [acc_pkg::CFG_IDX_W-1:0] index;
    logic [acc_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/acc_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module acc_cfg (
    input  wire logic      clk,
    input  wire logic      rst_n,
    acc_cfg_if.sink        cfg,
    output acc_pkg::cfg_t  regs
);

    logic [acc_pkg::LBA_W-1:0]  capacity_reg;
    logic [3:0]                 block_shift_reg;
    logic                       lba48_reg;
    logic [2:0]                 inject_mask_reg;
    logic [acc_pkg::LBA_W-1:0]  error_start_reg;
    logic [acc_pkg::ELEN_W-1:0] error_length_reg;
    logic [acc_pkg::LBA_W:0]    error_end_reg;

    // Writes are never held off
    assign cfg.ready = 1'b1;

    // Register file; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg     <= acc_pkg::CAP_RESET;
            block_shift_reg  <= acc_pkg::SHIFT_RESET;
            lba48_reg        <= 1'b1;
            inject_mask_reg  <= '0;
            error_start_reg  <= '0;
            error_length_reg <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (acc_pkg::cfg_idx_t'(cfg.index))
                acc_pkg::CFG_CAPACITY:  capacity_reg     <= cfg.data;
                acc_pkg::CFG_SHIFT:     block_shift_reg  <= cfg.data[3:0];
                acc_pkg::CFG_LBA48:     lba48_reg        <= cfg.data[0];
                acc_pkg::CFG_INJECT:    inject_mask_reg  <= cfg.data[2:0];
                acc_pkg::CFG_ERR_START: error_start_reg  <= cfg.data;
                acc_pkg::CFG_ERR_LEN:   error_length_reg <= cfg.data[acc_pkg::ELEN_W-1:0];
                default: ;
            endcase
        end
    end

    // End of the injected range, registered from the start and length registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            error_end_reg <= '0;
        else
            error_end_reg <= {1'b0, error_start_reg} + 49'(error_length_reg);
    end

    always_comb
    begin
        regs.capacity     = capacity_reg;
        regs.block_shift  = block_shift_reg;
        regs.lba48        = lba48_reg;
        regs.inject_mask  = inject_mask_reg;
        regs.error_start  = error_start_reg;
        regs.error_length = error_length_reg;
        regs.error_end    = error_end_reg;
    end

endmodule

`default_nettype wire

FILE: sv/ata_command_checker.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipeline: a command passes the input register, then the result register, before its
// response is valid.
// Throughput: one command per cycle; the input register stalls only while the response
// register is full and not taken.
// Reset (rst_n, asynchronous, active low) empties the pipeline, loads the register
// defaults and sets the mode words to 0x0000, 0x0407 and 0x003f.
module ata_command_checker (
    input  wire logic  clk,
    input  wire logic  rst_n,
    acc_cmd_if.sink    cmd,
    acc_rsp_if.source  rsp,
    acc_cfg_if.sink    cfg
);

    typedef struct packed {
        acc_pkg::err_code_t          err;
        acc_pkg::xfer_kind_t         kind;
        logic [acc_pkg::LBA_W-1:0]   lba;
        logic [acc_pkg::CNT_W-1:0]   cnt;
        logic                        rvalid;
        logic [acc_pkg::LBA_W-1:0]   rlba;
        logic [acc_pkg::MODE_W-1:0]  pio;
        logic [acc_pkg::MODE_W-1:0]  mwdma;
        logic [acc_pkg::MODE_W-1:0]  udma;
    } rsp_t;

    acc_pkg::cfg_t  regs;

    logic           a_valid_reg, o_valid_reg;
    acc_pkg::cmd_t  a_reg;
    acc_pkg::asm_t  cmd_asm;
    rsp_t           o_reg, o_next;

    logic [acc_pkg::MODE_W-1:0] pio_reg, mwdma_reg, udma_reg;

    logic a_free, o_free, a_move, accept;

    acc_cfg u_cfg (
        .clk  (clk),
        .rst_n(rst_n),
        .cfg  (cfg),
        .regs (regs)
    );

    // Pipeline flow control
    assign o_free    = !o_valid_reg || rsp.ready;
    assign a_free    = !a_valid_reg || o_free;
    assign a_move    = a_valid_reg && o_free;
    assign cmd.ready = a_free;
    assign accept    = cmd.valid && a_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= cmd.valid;
            if (o_free)
                o_valid_reg <= a_valid_reg;
        end
    end

    // Capture stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg.func         <= cmd.func;
            a_reg.lba_low_cur  <= cmd.lba_low_cur;
            a_reg.lba_mid_cur  <= cmd.lba_mid_cur;
            a_reg.lba_high_cur <= cmd.lba_high_cur;
            a_reg.lba_low_prv  <= cmd.lba_low_prv;
            a_reg.lba_mid_prv  <= cmd.lba_mid_prv;
            a_reg.lba_high_prv <= cmd.lba_high_prv;
            a_reg.head_reg     <= cmd.head_reg;
            a_reg.count_cur    <= cmd.count_cur;
            a_reg.count_prv    <= cmd.count_prv;
            a_reg.feature_reg  <= cmd.feature_reg;
            a_reg.buffer_bytes <= cmd.buffer_bytes;
        end
    end

    // Address and count assembly, end sector and byte length
    always_comb
    begin
        cmd_asm.func         = a_reg.func;
        cmd_asm.count_cur    = a_reg.count_cur;
        cmd_asm.feature_reg  = a_reg.feature_reg;
        cmd_asm.buffer_bytes = a_reg.buffer_bytes;
        if (regs.lba48)
        begin
            cmd_asm.lba = {a_reg.lba_high_prv, a_reg.lba_mid_prv, a_reg.lba_low_prv,
                           a_reg.lba_high_cur, a_reg.lba_mid_cur, a_reg.lba_low_cur};
            cmd_asm.cnt = {a_reg.count_prv, a_reg.count_cur};
        end
        else
        begin
            cmd_asm.lba = {20'h0, a_reg.head_reg[3:0],
                           a_reg.lba_high_cur, a_reg.lba_mid_cur, a_reg.lba_low_cur};
            cmd_asm.cnt = {8'h0, a_reg.count_cur};
        end
        cmd_asm.lba_end   = {1'b0, cmd_asm.lba} + 49'(cmd_asm.cnt);
        cmd_asm.req_bytes = 32'(cmd_asm.cnt) << regs.block_shift;
    end

    // Checks, verdict and mode word update
    logic over_cap, short_buf, hit, rd, wr;
    logic [3:0] mode_class;

    assign over_cap   = cmd_asm.lba_end > {1'b0, regs.capacity};
    assign short_buf  = cmd_asm.req_bytes > cmd_asm.buffer_bytes;
    assign hit        = (cmd_asm.cnt != '0) && (regs.error_length != '0)
                        && ({1'b0, cmd_asm.lba} < regs.error_end)
                        && ({1'b0, regs.error_start} < cmd_asm.lba_end);
    assign mode_class = cmd_asm.count_cur[7:4];

    always_comb
    begin
        o_next.err    = acc_pkg::ERR_NONE;
        o_next.kind   = acc_pkg::XFER_NONE;
        o_next.lba    = cmd_asm.lba;
        o_next.cnt    = cmd_asm.cnt;
        o_next.rvalid = 1'b0;
        o_next.rlba   = '0;
        o_next.pio    = pio_reg;
        o_next.mwdma  = mwdma_reg;
        o_next.udma   = udma_reg;
        rd            = 1'b0;
        wr            = 1'b0;

        unique case (cmd_asm.func)
            acc_pkg::OP_READ_EXT:
            begin
                if (!regs.lba48)
                    o_next.err = acc_pkg::ERR_ABORT;
                else
                    rd = 1'b1;
            end
            acc_pkg::OP_WRITE_EXT:
            begin
                if (!regs.lba48)
                    o_next.err = acc_pkg::ERR_ABORT;
                else
                    wr = 1'b1;
            end
            acc_pkg::OP_READ:  rd = 1'b1;
            acc_pkg::OP_WRITE: wr = 1'b1;
            acc_pkg::OP_VERIFY, acc_pkg::OP_VERIFY_EXT:
            begin
                if (over_cap)
                    o_next.err = acc_pkg::ERR_IDNF;
                else if (regs.inject_mask[acc_pkg::INJ_VERIFY] && hit)
                begin
                    o_next.err    = acc_pkg::ERR_ECC;
                    o_next.rvalid = 1'b1;
                    o_next.rlba   = (cmd_asm.func == acc_pkg::OP_VERIFY)
                                    ? (regs.error_start & acc_pkg::LBA28_MASK)
                                    : regs.error_start;
                end
            end
            acc_pkg::OP_SET_FEATURES:
            begin
                if (cmd_asm.feature_reg != acc_pkg::FEAT_XFER_MODE)
                    o_next.err = acc_pkg::ERR_ABORT;
                else if (mode_class == acc_pkg::MODE_PIO)
                    o_next.pio = acc_pkg::set_mode(pio_reg, cmd_asm.count_cur[3:0]);
                else if (mode_class == acc_pkg::MODE_MWDMA)
                    o_next.mwdma = acc_pkg::set_mode(mwdma_reg, cmd_asm.count_cur[3:0]);
                else if (mode_class == acc_pkg::MODE_UDMA)
                    o_next.udma = acc_pkg::set_mode(udma_reg, cmd_asm.count_cur[3:0]);
                else
                    o_next.err = acc_pkg::ERR_ABORT;
            end
            acc_pkg::OP_SET_MULTIPLE, acc_pkg::OP_CHECK_POWER, acc_pkg::OP_STANDBY,
            acc_pkg::OP_IDENTIFY, acc_pkg::OP_IDENTIFY_PKT, acc_pkg::OP_FLUSH,
            acc_pkg::OP_FLUSH_EXT: ;
            default: o_next.err = acc_pkg::ERR_ABORT;
        endcase

        // Data commands: capacity, then buffer, then injected range
        if (rd || wr)
        begin
            priority if (over_cap)
                o_next.err = acc_pkg::ERR_IDNF;
            else if (short_buf)
                o_next.err = acc_pkg::ERR_ABORT;
            else if ((rd ? regs.inject_mask[acc_pkg::INJ_READ]
                         : regs.inject_mask[acc_pkg::INJ_WRITE]) && hit)
                o_next.err = acc_pkg::ERR_ECC;
            else if (cmd_asm.cnt != '0)
                o_next.kind = rd ? acc_pkg::XFER_READ : acc_pkg::XFER_WRITE;
        end
    end

    // Mode words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pio_reg   <= acc_pkg::PIO_RESET;
            mwdma_reg <= acc_pkg::MWDMA_RESET;
            udma_reg  <= acc_pkg::UDMA_RESET;
        end
        else if (a_move)
        begin
            pio_reg   <= o_next.pio;
            mwdma_reg <= o_next.mwdma;
            udma_reg  <= o_next.udma;
        end
    end

    // Response register
    always_ff @(posedge clk)
    begin
        if (a_move)
            o_reg <= o_next;
    end

    assign rsp.valid         = o_valid_reg;
    assign rsp.status        = (o_reg.err != acc_pkg::ERR_NONE);
    assign rsp.error_code    = o_reg.err;
    assign rsp.transfer_kind = o_reg.kind;
    assign rsp.start_lba     = o_reg.lba;
    assign rsp.sector_total  = o_reg.cnt;
    assign rsp.report_valid  = o_reg.rvalid;
    assign rsp.report_lba    = o_reg.rlba;
    assign rsp.pio_word      = o_reg.pio;
    assign rsp.mwdma_word    = o_reg.mwdma;
    assign rsp.udma_word     = o_reg.udma;

    // Checks
    a_report_is_ecc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.report_valid |-> rsp.error_code == acc_pkg::ERR_ECC)
        else $error("error address reported without an ECC error");

    a_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.report_valid |-> rsp.report_lba == '0)
        else $error("error address not cleared");

    a_xfer_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.transfer_kind != acc_pkg::XFER_NONE
        |-> !rsp.status && rsp.sector_total != '0)
        else $error("transfer granted on a failed or empty command");

    a_mode_only_setf: assert property (@(posedge clk) disable iff (!rst_n)
        !(a_move && cmd_asm.func == acc_pkg::OP_SET_FEATURES)
        |=> $stable(pio_reg) && $stable(mwdma_reg) && $stable(udma_reg))
        else $error("mode word changed outside set features");

endmodule

`default_nettype wire

FILE: bench/ata_response_checker.sv
`timescale 1ns / 1ps

// Watches the command, response and register channels, decodes every accepted
// command into the response it must produce, and compares responses in order.
module ata_response_checker (
    input  logic clk,
    input  logic rst_n,
    acc_cmd_if   cmd,
    acc_rsp_if   rsp,
    acc_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);
    import acc_pkg::*;

    typedef struct packed {
        logic              status;
        err_code_t         error_code;
        xfer_kind_t        transfer_kind;
        logic [LBA_W-1:0]  start_lba;
        logic [CNT_W-1:0]  sector_total;
        logic              report_valid;
        logic [LBA_W-1:0]  report_lba;
        logic [MODE_W-1:0] pio_word;
        logic [MODE_W-1:0] mwdma_word;
        logic [MODE_W-1:0] udma_word;
    } response_t;

    // Register copy
    logic [LBA_W-1:0]  disk_cap;
    logic [3:0]        sector_shift;
    logic              wide_lba;
    logic [2:0]        inject_bits;
    logic [LBA_W-1:0]  bad_start;
    logic [ELEN_W-1:0] bad_len;

    // Mode words
    logic [MODE_W-1:0] pio_modes;
    logic [MODE_W-1:0] mwdma_modes;
    logic [MODE_W-1:0] udma_modes;

    response_t expected_responses[$];

    // Keep the supported byte, set the requested mode bit; bits past 15 are lost
    function automatic logic [MODE_W-1:0] mode_word(logic [MODE_W-1:0] w, logic [3:0] mode);
        logic [31:0] widened;
        widened = {16'd0, w & 16'h00ff} | (32'd1 << (mode + 5'd8));
        return widened[MODE_W-1:0];
    endfunction

    // Both ranges must be non-empty and overlap
    function automatic logic hits_bad_range(logic [LBA_W-1:0] s, logic [CNT_W-1:0] n);
        logic [LBA_W:0] bad_end;
        logic [LBA_W:0] cmd_end;
        if (n == 0 || bad_len == 0)
            return 1'b0;
        bad_end = {1'b0, bad_start} + {17'd0, bad_len};
        cmd_end = {1'b0, s} + {33'd0, n};
        return ({1'b0, s} < bad_end) && ({1'b0, bad_start} < cmd_end);
    endfunction

    // Decode one taskfile; updates the mode words on a set-features transfer
    function automatic response_t decode_command(cmd_t c);
        response_t      r;
        logic [LBA_W:0] lba_end;
        logic           rd;
        logic           wr;
        r = '0;
        rd = 1'b0;
        wr = 1'b0;
        r.error_code = ERR_NONE;
        r.transfer_kind = XFER_NONE;

        r.start_lba = {24'd0, c.lba_high_cur, c.lba_mid_cur, c.lba_low_cur};
        if (wide_lba)
        begin
            r.start_lba[47:24] = {c.lba_high_prv, c.lba_mid_prv, c.lba_low_prv};
            r.sector_total = {c.count_prv, c.count_cur};
        end
        else
        begin
            r.start_lba[27:24] = c.head_reg[3:0];
            r.sector_total = {8'd0, c.count_cur};
        end
        lba_end = {1'b0, r.start_lba} + {33'd0, r.sector_total};

        case (c.func)
            OP_READ_EXT, OP_WRITE_EXT:
            begin
                if (!wide_lba)
                    r.error_code = ERR_ABORT;
                else if (c.func == OP_READ_EXT)
                    rd = 1'b1;
                else
                    wr = 1'b1;
            end
            OP_READ:  rd = 1'b1;
            OP_WRITE: wr = 1'b1;
            OP_VERIFY, OP_VERIFY_EXT:
            begin
                if (lba_end > {1'b0, disk_cap})
                    r.error_code = ERR_IDNF;
                else if (inject_bits[INJ_VERIFY] && hits_bad_range(r.start_lba, r.sector_total))
                begin
                    r.error_code = ERR_ECC;
                    r.report_valid = 1'b1;
                    r.report_lba = (c.func == OP_VERIFY) ? (bad_start & LBA28_MASK) : bad_start;
                end
            end
            OP_SET_FEATURES:
            begin
                if (c.feature_reg != FEAT_XFER_MODE)
                    r.error_code = ERR_ABORT;
                else
                    case (c.count_cur[7:4])
                        MODE_PIO:   pio_modes = mode_word(pio_modes, c.count_cur[3:0]);
                        MODE_MWDMA: mwdma_modes = mode_word(mwdma_modes, c.count_cur[3:0]);
                        MODE_UDMA:  udma_modes = mode_word(udma_modes, c.count_cur[3:0]);
                        default:    r.error_code = ERR_ABORT;
                    endcase
            end
            OP_SET_MULTIPLE, OP_CHECK_POWER, OP_STANDBY, OP_IDENTIFY,
            OP_IDENTIFY_PKT, OP_FLUSH, OP_FLUSH_EXT: ;
            default: r.error_code = ERR_ABORT;
        endcase

        // Capacity, then buffer length, then injected bad sectors
        if (rd || wr)
        begin
            if (lba_end > {1'b0, disk_cap})
                r.error_code = ERR_IDNF;
            else if (({48'd0, r.sector_total} << sector_shift) > {32'd0, c.buffer_bytes})
                r.error_code = ERR_ABORT;
            else if (inject_bits[rd ? INJ_READ : INJ_WRITE]
                     && hits_bad_range(r.start_lba, r.sector_total))
                r.error_code = ERR_ECC;
            else if (r.sector_total != 0)
                r.transfer_kind = rd ? XFER_READ : XFER_WRITE;
        end

        r.status = (r.error_code != ERR_NONE);
        r.pio_word = pio_modes;
        r.mwdma_word = mwdma_modes;
        r.udma_word = udma_modes;
        return r;
    endfunction

    task automatic compare_field(string name, logic [LBA_W-1:0] want, logic [LBA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        cmd_t      seen;
        response_t want;
        if (!rst_n)
        begin
            disk_cap = CAP_RESET;
            sector_shift = SHIFT_RESET;
            wide_lba = 1'b1;
            inject_bits = '0;
            bad_start = '0;
            bad_len = '0;
            pio_modes = PIO_RESET;
            mwdma_modes = MWDMA_RESET;
            udma_modes = UDMA_RESET;
            expected_responses.delete();
            mismatches = 0;
            outstanding <= 0;
        end
        else
        begin
            // Register writes
            if (cfg.valid && cfg.ready)
                case (cfg.index)
                    CFG_CAPACITY:  disk_cap = cfg.data;
                    CFG_SHIFT:     sector_shift = cfg.data[3:0];
                    CFG_LBA48:     wide_lba = cfg.data[0];
                    CFG_INJECT:    inject_bits = cfg.data[2:0];
                    CFG_ERR_START: bad_start = cfg.data;
                    CFG_ERR_LEN:   bad_len = cfg.data[ELEN_W-1:0];
                    default: ;
                endcase

            // Command transfer: predict its response
            if (cmd.valid && cmd.ready)
            begin
                seen.func = cmd.func;
                seen.lba_low_cur = cmd.lba_low_cur;
                seen.lba_mid_cur = cmd.lba_mid_cur;
                seen.lba_high_cur = cmd.lba_high_cur;
                seen.lba_low_prv = cmd.lba_low_prv;
                seen.lba_mid_prv = cmd.lba_mid_prv;
                seen.lba_high_prv = cmd.lba_high_prv;
                seen.head_reg = cmd.head_reg;
                seen.count_cur = cmd.count_cur;
                seen.count_prv = cmd.count_prv;
                seen.feature_reg = cmd.feature_reg;
                seen.buffer_bytes = cmd.buffer_bytes;
                expected_responses.push_back(decode_command(seen));
            end

            // Response transfer: compare with the oldest prediction
            if (rsp.valid && rsp.ready)
            begin
                if (expected_responses.size() == 0)
                begin
                    $error("response transfer with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_responses.pop_front();
                    compare_field("status", 48'(want.status), 48'(rsp.status));
                    compare_field("error_code", 48'(want.error_code), 48'(rsp.error_code));
                    compare_field("transfer_kind", 48'(want.transfer_kind),
                                  48'(rsp.transfer_kind));
                    compare_field("start_lba", want.start_lba, rsp.start_lba);
                    compare_field("sector_total", 48'(want.sector_total), 48'(rsp.sector_total));
                    compare_field("report_valid", 48'(want.report_valid), 48'(rsp.report_valid));
                    compare_field("report_lba", want.report_lba, rsp.report_lba);
                    compare_field("pio_word", 48'(want.pio_word), 48'(rsp.pio_word));
                    compare_field("mwdma_word", 48'(want.mwdma_word), 48'(rsp.mwdma_word));
                    compare_field("udma_word", 48'(want.udma_word), 48'(rsp.udma_word));
                end
            end
            outstanding <= expected_responses.size();
        end
    end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import acc_pkg::*;

    localparam logic [LBA_W-1:0] MAX_LBA         = {LBA_W{1'b1}};
    localparam logic [7:0]       OP_UNDEFINED_LO = 8'h00;
    localparam logic [7:0]       OP_UNDEFINED_HI = 8'hFF;
    localparam logic [7:0]       FEAT_OTHER      = 8'h02;
    localparam logic [3:0]       MODE_UNKNOWN    = 4'h8;
    localparam int PHASES         = 14;
    localparam int PHASE_ITEMS    = 125;
    localparam int TAIL_PHASES    = 2;
    localparam int SETTLE_CYCLES  = 10;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic [7:0] MOVE_OPS [6] = '{OP_READ, OP_READ_EXT, OP_WRITE, OP_WRITE_EXT,
                                            OP_VERIFY, OP_VERIFY_EXT};
    localparam logic [7:0] BENIGN_OPS [7] = '{OP_SET_MULTIPLE, OP_CHECK_POWER, OP_STANDBY,
                                              OP_IDENTIFY, OP_IDENTIFY_PKT, OP_FLUSH,
                                              OP_FLUSH_EXT};

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   quiet_cycles = 0;

    // Idling control
    bit   steady_tail = 1'b0;
    int   cmd_idle_pct = 20;
    int   rsp_stall_pct = 10;

    // Current register settings, used to aim the random commands
    logic [LBA_W-1:0]  disk_cap = CAP_RESET;
    logic [3:0]        sector_shift = SHIFT_RESET;
    logic              wide_lba = 1'b1;
    logic [LBA_W-1:0]  bad_start = '0;

    acc_cmd_if cmd_ch ();
    acc_rsp_if rsp_ch ();
    acc_cfg_if cfg_ch ();

    ata_command_checker DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ata_response_checker CHK (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .cfg         (cfg_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // Taskfile with 48-bit address bytes and the 28-bit nibble in the head register
    function automatic cmd_t taskfile(logic [7:0] op, logic [LBA_W-1:0] lba,
                                      logic [CNT_W-1:0] count, logic [BUF_W-1:0] host);
        cmd_t c;
        c = '0;
        c.func = op;
        {c.lba_high_cur, c.lba_mid_cur, c.lba_low_cur} = lba[23:0];
        {c.lba_high_prv, c.lba_mid_prv, c.lba_low_prv} = lba[47:24];
        c.head_reg = {4'hE, lba[27:24]};
        {c.count_prv, c.count_cur} = count;
        c.buffer_bytes = host;
        return c;
    endfunction

    function automatic cmd_t mode_request(logic [7:0] sub, logic [3:0] cls, logic [3:0] mode);
        cmd_t c;
        c = '0;
        c.func = OP_SET_FEATURES;
        c.feature_reg = sub;
        c.count_cur = {cls, mode};
        return c;
    endfunction

    // Random command aimed at the capacity edge and the bad-sector range
    function automatic cmd_t random_command();
        cmd_t             c;
        logic [LBA_W-1:0] lba;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] moved;
        logic [BUF_W-1:0] need;
        logic [3:0]       cls;
        int               pick;
        c.feature_reg = 8'($urandom);
        c.head_reg = 8'($urandom);
        c.count_prv = 8'($urandom);
        {c.lba_high_prv, c.lba_mid_prv, c.lba_low_prv} = 24'($urandom);

        pick = $urandom_range(0, 99);
        if (pick < 72)
            c.func = MOVE_OPS[$urandom_range(0, 5)];
        else if (pick < 84)
            c.func = OP_SET_FEATURES;
        else if (pick < 92)
            c.func = BENIGN_OPS[$urandom_range(0, 6)];
        else
            c.func = 8'($urandom);

        case ($urandom_range(0, 3))
            0:       lba = {16'($urandom), 32'($urandom)};
            1:       lba = bad_start + 48'($urandom_range(0, 40)) - 48'd20;
            2:       lba = disk_cap - 48'($urandom_range(0, 300));
            default: lba = 48'($urandom_range(0, 1000));
        endcase
        if (!wide_lba)
            lba[47:28] = '0;

        case ($urandom_range(0, 5))
            0:       count = '0;
            1:       count = 16'($urandom);
            2:       count = 16'($urandom_range(1, 16));
            default: count = 16'($urandom_range(0, 300));
        endcase

        {c.lba_high_cur, c.lba_mid_cur, c.lba_low_cur} = lba[23:0];
        c.count_cur = count[7:0];
        if (wide_lba)
        begin
            {c.lba_high_prv, c.lba_mid_prv, c.lba_low_prv} = lba[47:24];
            c.count_prv = count[15:8];
            moved = count;
        end
        else
        begin
            c.head_reg[3:0] = lba[27:24];
            moved = {8'd0, count[7:0]};
        end

        // Buffer length around the exact need
        need = 32'(moved) << sector_shift;
        case ($urandom_range(0, 3))
            0:       c.buffer_bytes = need + 32'($urandom_range(0, 2)) - 32'd1;
            1:       c.buffer_bytes = $urandom;
            2:       c.buffer_bytes = '1;
            default: c.buffer_bytes = need + 32'($urandom_range(0, 4096));
        endcase

        if (c.func == OP_SET_FEATURES)
        begin
            case ($urandom_range(0, 3))
                0:       cls = MODE_PIO;
                1:       cls = MODE_MWDMA;
                2:       cls = MODE_UDMA;
                default: cls = 4'($urandom);
            endcase
            c.count_cur = {cls, 4'($urandom)};
            if ($urandom_range(0, 7) != 0)
                c.feature_reg = FEAT_XFER_MODE;
        end
        return c;
    endfunction

    // Hold the command until transferred
    task automatic present_command(cmd_t c);
        cmd_ch.valid <= 1'b1;
        cmd_ch.func <= c.func;
        cmd_ch.lba_low_cur <= c.lba_low_cur;
        cmd_ch.lba_mid_cur <= c.lba_mid_cur;
        cmd_ch.lba_high_cur <= c.lba_high_cur;
        cmd_ch.lba_low_prv <= c.lba_low_prv;
        cmd_ch.lba_mid_prv <= c.lba_mid_prv;
        cmd_ch.lba_high_prv <= c.lba_high_prv;
        cmd_ch.head_reg <= c.head_reg;
        cmd_ch.count_cur <= c.count_cur;
        cmd_ch.count_prv <= c.count_prv;
        cmd_ch.feature_reg <= c.feature_reg;
        cmd_ch.buffer_bytes <= c.buffer_bytes;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_command(cmd_t c);
        if (!steady_tail && $urandom_range(0, 99) < cmd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        present_command(c);
    endtask

    task automatic program_register(cfg_idx_t idx, logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Drain the block, then write every register
    task automatic apply_settings(logic [LBA_W-1:0] cap, logic [3:0] shift, logic wide,
                                  logic [2:0] inj, logic [LBA_W-1:0] es,
                                  logic [ELEN_W-1:0] el);
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        program_register(CFG_CAPACITY, cap);
        program_register(CFG_SHIFT, 48'(shift));
        program_register(CFG_LBA48, 48'(wide));
        program_register(CFG_INJECT, 48'(inj));
        program_register(CFG_ERR_START, es);
        program_register(CFG_ERR_LEN, 48'(el));
        cfg_ch.valid <= 1'b0;
        disk_cap = cap;
        sector_shift = shift;
        wide_lba = wide;
        bad_start = es;
    endtask

    // Response back-pressure in random bursts
    initial
    begin
        rsp_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!steady_tail && $urandom_range(0, 99) < rsp_stall_pct)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Stimulus and verdict
    initial
    begin
        logic [LBA_W-1:0]  cap;
        logic [LBA_W-1:0]  es;
        logic [3:0]        shift;
        logic              wide;
        logic [2:0]        inj;
        logic [ELEN_W-1:0] el;
        logic [LBA_W-1:0]  spot;

        rst_n <= 1'b0;
        cmd_ch.valid <= 1'b0;
        cmd_ch.func <= '0;
        cmd_ch.lba_low_cur <= '0;
        cmd_ch.lba_mid_cur <= '0;
        cmd_ch.lba_high_cur <= '0;
        cmd_ch.lba_low_prv <= '0;
        cmd_ch.lba_mid_prv <= '0;
        cmd_ch.lba_high_prv <= '0;
        cmd_ch.head_reg <= '0;
        cmd_ch.count_cur <= '0;
        cmd_ch.count_prv <= '0;
        cmd_ch.feature_reg <= '0;
        cmd_ch.buffer_bytes <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= '0;
        cfg_ch.data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: register defaults
        send_command(taskfile(OP_READ, 48'd0, 16'd1, 32'd512));
        send_command(taskfile(OP_READ_EXT, CAP_RESET - 48'd8, 16'd8, 32'd4096));
        send_command(taskfile(OP_READ_EXT, CAP_RESET - 48'd8, 16'd9, '1));
        send_command(taskfile(OP_WRITE, 48'd100, 16'd16, 32'd8191));
        send_command(taskfile(OP_WRITE_EXT, 48'd100, 16'd0, 32'd0));
        send_command(taskfile(OP_VERIFY, MAX_LBA, '1, '1));
        send_command(taskfile(OP_VERIFY_EXT, 48'd0, 16'd0, 32'd0));
        send_command(mode_request(FEAT_XFER_MODE, MODE_PIO, 4'hC));
        send_command(mode_request(FEAT_XFER_MODE, MODE_PIO, 4'h4));
        send_command(mode_request(FEAT_XFER_MODE, MODE_MWDMA, 4'h2));
        send_command(mode_request(FEAT_XFER_MODE, MODE_UDMA, 4'hF));
        send_command(mode_request(FEAT_XFER_MODE, MODE_UNKNOWN, 4'h0));
        send_command(mode_request(FEAT_OTHER, MODE_UDMA, 4'h1));
        for (int i = 0; i < 7; i++)
            send_command(taskfile(BENIGN_OPS[i], 48'd0, 16'd0, 32'd0));
        send_command(taskfile(OP_UNDEFINED_LO, 48'd5, 16'd5, 32'd0));
        send_command(taskfile(OP_UNDEFINED_HI, MAX_LBA, '1, '1));

        // Directed: 28-bit addressing, extended commands
        apply_settings(CAP_RESET, SHIFT_RESET, 1'b0, 3'd0, 48'd0, 32'd0);
        send_command(taskfile(OP_READ_EXT, 48'd16, 16'd1, '1));
        send_command(taskfile(OP_VERIFY_EXT, 48'hABC_0AB_CDEF, 16'h1234, 32'd0));

        // Directed: injected bad sectors, verify reports both address forms
        spot = 48'h1234_5678_9ABC;
        apply_settings(MAX_LBA, 4'd12, 1'b1, 3'd7, spot, 32'd16);
        send_command(taskfile(OP_VERIFY, spot + 48'd4, 16'd2, 32'd0));
        send_command(taskfile(OP_VERIFY_EXT, spot + 48'd4, 16'd2, 32'd0));
        send_command(taskfile(OP_READ, spot - 48'd1, 16'd2, '1));
        send_command(taskfile(OP_WRITE_EXT, spot + 48'd15, 16'd1, '1));
        send_command(taskfile(OP_WRITE_EXT, spot + 48'd16, 16'd1, '1));

        // Random phases, each with its own register settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            shift = 4'(9 + ph % 4);
            inj = (ph < 8) ? 3'(ph) : 3'($urandom);
            case (ph)
                0:
                begin
                    cap = 48'd1;
                    wide = 1'b1;
                    es = '0;
                    el = '1;
                end
                1:
                begin
                    cap = MAX_LBA;
                    wide = 1'b1;
                    es = MAX_LBA;
                    el = 32'd1;
                end
                2:
                begin
                    cap = 48'h1000_0000;
                    wide = 1'b0;
                    es = 48'h0FFF_FF00;
                    el = 32'd512;
                end
                default:
                begin
                    wide = ($urandom_range(0, 2) != 0);
                    case ($urandom_range(0, 2))
                        0:       cap = 48'($urandom_range(1, 1 << 20));
                        1:       cap = {16'($urandom), 32'($urandom)} | 48'd1;
                        default: cap = 48'($urandom_range(1, 32'h1000_0000));
                    endcase
                    if (wide)
                        es = {16'($urandom), 32'($urandom)} % cap;
                    else
                        es = 48'($urandom_range(0, 32'h0FFF_FFFF)) % cap;
                    case ($urandom_range(0, 3))
                        0:       el = '0;
                        1:       el = 32'($urandom_range(1, 64));
                        2:       el = $urandom;
                        default: el = '1;
                    endcase
                end
            endcase
            apply_settings(cap, shift, wide, inj, es, el);

            steady_tail = (ph >= PHASES - TAIL_PHASES);
            case ($urandom_range(0, 2))
                0:       cmd_idle_pct = 0;
                1:       cmd_idle_pct = 10;
                default: cmd_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       rsp_stall_pct = 0;
                1:       rsp_stall_pct = 4;
                default: rsp_stall_pct = 20;
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_command(random_command());
        end

        // Wait for the last responses, then let the pipeline settle
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
sv/acc_pkg.sv
sv/acc_if.sv
sv/acc_cfg.sv
sv/ata_command_checker.sv
bench/ata_response_checker.sv
bench/testbench.sv
